// File: hdl/frx_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Shared types and codes for the framed packet receiver.
// ----------------------------------------------------------------------------
package frx_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned CIDX_W  = 2;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_TRL1 = 3'd5,
        PH_TRL2 = 3'd6
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE = 3'd0,
        ERR_HDR1 = 3'd1,
        ERR_HDR2 = 3'd2,
        ERR_TRL1 = 3'd3,
        ERR_TRL2 = 3'd4
    } t_err;

    typedef enum logic [CIDX_W-1:0] {
        CFG_HDR1 = 2'd0,
        CFG_HDR2 = 2'd1,
        CFG_TRL1 = 2'd2,
        CFG_TRL2 = 2'd3
    } t_cfg_idx;

    localparam t_byte HDR1_RST = 8'hAB;
    localparam t_byte HDR2_RST = 8'hCD;
    localparam t_byte TRL1_RST = 8'hE1;
    localparam t_byte TRL2_RST = 8'hE2;

    typedef struct packed {
        t_byte hdr1;
        t_byte hdr2;
        t_byte trl1;
        t_byte trl2;
    } t_cfg;

    typedef struct packed {
        t_kind kind;
        t_err  err;
        t_byte cmd;
        t_byte len;
        t_byte data;
        t_byte idx;
        logic  last;
    } t_result;

endpackage

// File: hdl/frx_cfg.sv
// ----------------------------------------------------------------------------
// Framed packet receiver configuration registers
// Holds the expected header and trailer byte values.
// ----------------------------------------------------------------------------
module frx_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  frx_pkg::t_cfg_idx i_cfg_index,
    input  frx_pkg::t_byte   i_cfg_data,
    output frx_pkg::t_cfg    o_cfg
);
    import frx_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HDR1: n_cfg.hdr1 = i_cfg_data;
                CFG_HDR2: n_cfg.hdr2 = i_cfg_data;
                CFG_TRL1: n_cfg.trl1 = i_cfg_data;
                CFG_TRL2: n_cfg.trl2 = i_cfg_data;
                default:  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{hdr1: HDR1_RST, hdr2: HDR2_RST, trl1: TRL1_RST, trl2: TRL2_RST};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/frx_in_stage.sv
// ----------------------------------------------------------------------------
// Framed packet receiver input stage
// Registers each received item and holds it until the deframer takes it.
// ----------------------------------------------------------------------------
module frx_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  frx_pkg::t_byte i_rx_byte,
    input  logic           i_take,
    output logic           o_valid,
    output frx_pkg::t_byte o_byte
);
    import frx_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_byte r_byte;
    logic  load;

    assign o_in_stall = r_valid && !i_take;
    assign load       = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: hdl/frx_deframer.sv
// ----------------------------------------------------------------------------
// Framed packet receiver deframer
// Phase machine that parses frames and registers payload and status results.
// ----------------------------------------------------------------------------
module frx_deframer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  frx_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    input  frx_pkg::t_byte  i_byte,
    output logic            o_take,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output frx_pkg::t_result o_result
);
    import frx_pkg::*;

    t_phase  r_phase;
    t_phase  n_phase;
    t_byte   r_cmd;
    t_byte   n_cmd;
    t_byte   r_len;
    t_byte   n_len;
    t_byte   r_count;
    t_byte   n_count;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    t_result n_result;
    logic    emit;
    logic    last;
    logic [BYTE_W:0] count_inc;

    assign o_take    = i_valid && (!r_out_valid || !i_out_stall);
    assign count_inc = {1'b0, r_count} + {{BYTE_W{1'b0}}, 1'b1};
    assign last      = (count_inc >= {1'b0, r_len});

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_count  = r_count;
        emit     = 1'b0;
        n_result = '{kind: KIND_REJECT, err: ERR_NONE, cmd: r_cmd, len: r_len,
                     data: '0, idx: '0, last: 1'b0};
        unique case (r_phase)
            PH_HDR2: begin
                if (i_byte == i_cfg.hdr2) begin
                    n_phase = PH_CMD;
                end else begin
                    n_phase      = PH_HDR1;
                    emit         = 1'b1;
                    n_result.err = ERR_HDR2;
                    n_result.cmd = '0;
                    n_result.len = '0;
                end
            end
            PH_CMD: begin
                n_cmd   = i_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_count = '0;
                n_phase = (i_byte == '0) ? PH_TRL1 : PH_DATA;
            end
            PH_DATA: begin
                emit          = 1'b1;
                n_result.kind = KIND_PAYLOAD;
                n_result.data = i_byte;
                n_result.idx  = r_count;
                n_result.last = last;
                n_count       = count_inc[BYTE_W-1:0];
                if (last) begin
                    n_phase = PH_TRL1;
                end
            end
            PH_TRL1: begin
                if (i_byte == i_cfg.trl1) begin
                    n_phase = PH_TRL2;
                end else begin
                    n_phase      = PH_HDR1;
                    emit         = 1'b1;
                    n_result.err = ERR_TRL1;
                end
            end
            PH_TRL2: begin
                n_phase = PH_HDR1;
                emit    = 1'b1;
                if (i_byte == i_cfg.trl2) begin
                    n_result.kind = KIND_ACCEPT;
                end else begin
                    n_result.err = ERR_TRL2;
                end
            end
            default: begin
                if (i_byte == i_cfg.hdr1) begin
                    n_phase = PH_HDR2;
                end else begin
                    n_phase      = PH_HDR1;
                    emit         = 1'b1;
                    n_result.err = ERR_HDR1;
                    n_result.cmd = '0;
                    n_result.len = '0;
                end
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_take) begin
            n_out_valid = emit;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR1;
            r_cmd       <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_len   <= n_len;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// File: hdl/framed_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// Framed packet receiver top level
// Deframes header, command, length, payload and trailer bytes into results.
//
//   Channel  Handshake                 Payload
//   input    i_in_valid / o_in_stall   i_rx_byte
//   output   o_out_valid / i_out_stall o_result_kind ... o_last_payload
//   config   i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item is accepted per cycle while o_in_stall is low; any result
// is held in an output register set by the phase machine.
// Reset is synchronous and active low; it restores the default header and
// trailer bytes and returns the phase machine to the header hunt.
// A stalled result holds the phase machine; one further item waits in the
// input register before the input channel stalls.
// ----------------------------------------------------------------------------
module framed_packet_receiver_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [frx_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [frx_pkg::KIND_W-1:0]   o_result_kind,
    output logic [frx_pkg::ERR_W-1:0]    o_error_code,
    output logic [frx_pkg::BYTE_W-1:0]   o_frame_cmd,
    output logic [frx_pkg::BYTE_W-1:0]   o_frame_length,
    output logic [frx_pkg::BYTE_W-1:0]   o_payload_byte,
    output logic [frx_pkg::BYTE_W-1:0]   o_payload_index,
    output logic                         o_last_payload,
    input  logic                         i_cfg_we,
    input  logic [frx_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [frx_pkg::BYTE_W-1:0]   i_cfg_data
);
    import frx_pkg::*;

    t_cfg    cfg;
    logic    stage_valid;
    t_byte   stage_byte;
    logic    take;
    t_result result;

    frx_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    frx_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_take     (take),
        .o_valid    (stage_valid),
        .o_byte     (stage_byte)
    );

    frx_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (stage_valid),
        .i_byte      (stage_byte),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_result_kind   = result.kind;
    assign o_error_code    = result.err;
    assign o_frame_cmd     = result.cmd;
    assign o_frame_length  = result.len;
    assign o_payload_byte  = result.data;
    assign o_payload_index = result.idx;
    assign o_last_payload  = result.last;

endmodule
